// ===== design/wavhp_pkg.sv =====
// Package for the WAV header parser: beat types, parser state, result and error codes.
// No dependencies; used by wavhp_step and wav_header_parser_unit.
`default_nettype none
package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [4:0]  FMT_BODY = 5'd16;
	localparam logic [4:0]  WORD_BYTES = 5'd4;
	localparam logic [15:0] FMT_PCM = 16'd1;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NOT_RIFF = 3'd1;
	localparam logic [2:0] ERR_NOT_WAVE = 3'd2;
	localparam logic [2:0] ERR_NOT_PCM  = 3'd3;
	localparam logic [2:0] ERR_NO_FMT   = 3'd4;
	localparam logic [2:0] ERR_NO_DATA  = 3'd5;
	localparam logic [2:0] ERR_SHORT    = 3'd6;

	typedef enum logic [9:0] {
		PH_RIFF  = 10'b00_0000_0001,
		PH_FSIZE = 10'b00_0000_0010,
		PH_WAVE  = 10'b00_0000_0100,
		PH_CID   = 10'b00_0000_1000,
		PH_CSIZE = 10'b00_0001_0000,
		PH_FMT   = 10'b00_0010_0000,
		PH_SKIP  = 10'b00_0100_0000,
		PH_DATA  = 10'b00_1000_0000,
		PH_DONE  = 10'b01_0000_0000,
		PH_HALT  = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [2:0]  error_code;
		logic [15:0] format_tag;
		logic [15:0] channel_count;
		logic [31:0] sample_rate_hz;
		logic [31:0] bytes_per_second;
		logic [15:0] frame_bytes;
		logic [15:0] sample_bits;
		logic [31:0] payload_length;
		logic [7:0]  payload_byte;
		logic        last_payload;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  pos;
		logic [31:0] asm_word;
		logic [31:0] tag_word;
		logic [31:0] remaining;
		logic        have_fmt;
		logic [15:0] fmt_tag;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [31:0] avg_bps;
		logic [15:0] align;
		logic [15:0] bits;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_RIFF, pos: '0, asm_word: '0, tag_word: '0, remaining: '0,
		have_fmt: 1'b0, fmt_tag: '0, channels: '0, rate: '0, avg_bps: '0,
		align: '0, bits: '0
	};

endpackage
`default_nettype wire

// ===== design/wavhp_step.sv =====
// Next-state and result logic of the WAV header parser for one input beat.
// Depends on wavhp_pkg.
`default_nettype none
module wavhp_step (
	input  wire wavhp_pkg::parse_state_t cur,
	input  wire wavhp_pkg::in_item_t     item,
	output wavhp_pkg::parse_state_t      nxt,
	output logic                         has_result,
	output wavhp_pkg::out_item_t         result
);
	import wavhp_pkg::*;

	logic [31:0] tag_sh;
	logic [31:0] asm_sh;
	logic [4:0]  pos_inc;
	logic [31:0] rem_dec;
	logic [2:0]  eof_code;

	assign tag_sh  = {item.in_byte, cur.tag_word[31:8]};
	assign asm_sh  = {item.in_byte, cur.asm_word[31:8]};
	assign pos_inc = cur.pos + 5'd1;
	assign rem_dec = cur.remaining - 32'd1;

	always_comb begin
		unique case (cur.phase)
			PH_RIFF:                   eof_code = ERR_NOT_RIFF;
			PH_FSIZE, PH_WAVE:         eof_code = ERR_NOT_WAVE;
			PH_CID, PH_CSIZE, PH_FMT,
			PH_SKIP:                   eof_code = cur.have_fmt ? ERR_NO_DATA : ERR_NO_FMT;
			PH_DATA:                   eof_code = ERR_SHORT;
			default:                   eof_code = ERR_NONE;
		endcase
	end

	always_comb begin
		nxt        = cur;
		has_result = 1'b0;
		result     = '0;
		if (item.end_of_file) begin
			// rearm on every end of file
			nxt = STATE_RESET;
			if (eof_code != ERR_NONE) begin
				has_result        = 1'b1;
				result.result_kind = KIND_ERROR;
				result.error_code  = eof_code;
			end
		end else begin
			unique case (cur.phase)
				PH_RIFF, PH_WAVE: begin
					nxt.tag_word = tag_sh;
					nxt.pos      = pos_inc;
					if (pos_inc == WORD_BYTES) begin
						nxt.pos = '0;
						if (cur.phase == PH_RIFF) begin
							if (tag_sh != TAG_RIFF) begin
								nxt.phase          = PH_HALT;
								has_result         = 1'b1;
								result.result_kind = KIND_ERROR;
								result.error_code  = ERR_NOT_RIFF;
							end else begin
								nxt.phase = PH_FSIZE;
							end
						end else begin
							if (tag_sh != TAG_WAVE) begin
								nxt.phase          = PH_HALT;
								has_result         = 1'b1;
								result.result_kind = KIND_ERROR;
								result.error_code  = ERR_NOT_WAVE;
							end else begin
								nxt.phase = PH_CID;
							end
						end
					end
				end
				PH_FSIZE: begin
					nxt.asm_word = asm_sh;
					nxt.pos      = pos_inc;
					if (pos_inc == WORD_BYTES) begin
						nxt.pos   = '0;
						nxt.phase = PH_WAVE;
					end
				end
				PH_CID: begin
					nxt.tag_word = tag_sh;
					nxt.pos      = pos_inc;
					if (pos_inc == WORD_BYTES) begin
						nxt.pos   = '0;
						nxt.phase = PH_CSIZE;
					end
				end
				PH_CSIZE: begin
					nxt.asm_word = asm_sh;
					nxt.pos      = pos_inc;
					if (pos_inc == WORD_BYTES) begin
						nxt.pos = '0;
						if (cur.tag_word == TAG_FMT) begin
							// fmt body is 16 bytes; skip whatever follows
							nxt.remaining = (asm_sh > 32'(FMT_BODY)) ?
								asm_sh - 32'(FMT_BODY) : '0;
							nxt.phase = PH_FMT;
						end else if (cur.tag_word == TAG_DATA) begin
							if (!cur.have_fmt) begin
								nxt.phase          = PH_HALT;
								has_result         = 1'b1;
								result.result_kind = KIND_ERROR;
								result.error_code  = ERR_NO_FMT;
							end else begin
								has_result              = 1'b1;
								result.result_kind      = KIND_HEADER;
								result.format_tag       = cur.fmt_tag;
								result.channel_count    = cur.channels;
								result.sample_rate_hz   = cur.rate;
								result.bytes_per_second = cur.avg_bps;
								result.frame_bytes      = cur.align;
								result.sample_bits      = cur.bits;
								result.payload_length   = asm_sh;
								result.last_payload     = (asm_sh == '0);
								nxt.remaining           = asm_sh;
								nxt.phase = (asm_sh == '0) ? PH_DONE : PH_DATA;
							end
						end else begin
							nxt.remaining = asm_sh;
							nxt.phase     = (asm_sh == '0) ? PH_CID : PH_SKIP;
						end
					end
				end
				PH_FMT: begin
					nxt.asm_word = asm_sh;
					unique case (cur.pos)
						5'd1:    nxt.fmt_tag   = asm_sh[31:16];
						5'd3:    nxt.channels  = asm_sh[31:16];
						5'd7:    nxt.rate      = asm_sh;
						5'd11:   nxt.avg_bps   = asm_sh;
						5'd13:   nxt.align     = asm_sh[31:16];
						5'd15:   nxt.bits      = asm_sh[31:16];
						default: ;
					endcase
					nxt.pos = pos_inc;
					if (pos_inc == FMT_BODY) begin
						nxt.pos      = '0;
						nxt.have_fmt = 1'b1;
						if (cur.fmt_tag != FMT_PCM) begin
							nxt.phase          = PH_HALT;
							has_result         = 1'b1;
							result.result_kind = KIND_ERROR;
							result.error_code  = ERR_NOT_PCM;
						end else begin
							nxt.phase = (cur.remaining == '0) ? PH_CID : PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					nxt.remaining = rem_dec;
					if (rem_dec == '0) begin
						nxt.phase = PH_CID;
					end
				end
				PH_DATA: begin
					has_result          = 1'b1;
					result.result_kind  = KIND_PAYLOAD;
					result.payload_byte = item.in_byte;
					result.last_payload = (cur.remaining == 32'd1);
					nxt.remaining       = rem_dec;
					if (rem_dec == '0) begin
						nxt.phase = PH_DONE;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/wav_header_parser_unit.sv =====
// A result is registered in the output register at the edge that accepts its input beat.
// Throughput: one input beat per cycle while byte_stall is low; the parser state updates in
// the cycle of acceptance, and the output register reloads in the same cycle that its waiting
// result is taken. byte_stall rises only while the output register is full and stalled.
// Reset (arst_n low, asynchronous): parser expects the RIFF tag, output register is empty.
// Top level of the WAV header parser; depends on wavhp_pkg and wavhp_step.
`default_nettype none
module wav_header_parser_unit (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   byte_valid,
	output logic                  byte_stall,
	input  wire wavhp_pkg::in_item_t  byte_item,
	output logic                  res_valid,
	input  wire                   res_stall,
	output wavhp_pkg::out_item_t  res_item
);
	import wavhp_pkg::*;

	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         step_has_result;
	out_item_t    step_result;
	logic         accept;
	out_item_t    res_q;
	logic         res_valid_q;

	wavhp_step u_step (
		.cur        (state_q),
		.item       (byte_item),
		.nxt        (state_nxt),
		.has_result (step_has_result),
		.result     (step_result)
	);

	assign byte_stall = res_valid_q & res_stall;
	assign accept     = byte_valid & ~byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// load on a beat with a result, drain when the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && step_has_result) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && step_has_result) begin
			res_q <= step_result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule
`default_nettype wire

// ===== bench/wav_header_parser_unit_test.sv =====
// Self-checking bench for wav_header_parser_unit: short directed byte table, then random WAV files.
// Needs wavhp_pkg (beat types, result and error codes, phase enum) and the parser RTL.
`timescale 1ns / 1ps
module wav_header_parser_unit_test;
	import wavhp_pkg::*;

	localparam logic [31:0] RIFF_ID = 32'h4646_4952;
	localparam logic [31:0] WAVE_ID = 32'h4556_4157;
	localparam logic [31:0] FMT_ID = 32'h2074_6D66;
	localparam logic [31:0] DATA_ID = 32'h6174_6164;
	localparam int ITEM_TARGET = 1050;

	typedef struct {
		in_item_t  beat;
		bit        typed;
		bit        has_want;
		out_item_t want;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	in_item_t byte_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_item_t res_item;

	// parser mirror
	phase_t      pr_phase;
	logic [4:0]  pr_pos;
	logic [31:0] pr_word;
	logic [31:0] pr_tag;
	logic [31:0] pr_left;
	logic        fmt_seen;
	logic [15:0] fmt_code;
	logic [15:0] fmt_channels;
	logic [31:0] fmt_rate;
	logic [31:0] fmt_avg_bps;
	logic [15:0] fmt_align;
	logic [15:0] fmt_bits;

	out_item_t results_due[$];
	probe_row_t probe_rows[$];
	logic [7:0] file_bytes[$];
	int mismatches = 0;
	int sent_items = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	wav_header_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	// toggle quiet stretches with no idling on either side
	initial begin
		forever begin
			repeat ($urandom_range(100, 400)) @(negedge clk);
			calm = ($urandom_range(0, 3) == 0);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic out_item_t error_beat(logic [2:0] code);
		out_item_t r;
		r = '0;
		r.result_kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	task automatic parser_clear();
		pr_phase = PH_RIFF;
		pr_pos = '0;
		pr_word = '0;
		pr_tag = '0;
		pr_left = '0;
		fmt_seen = 1'b0;
		fmt_code = '0;
		fmt_channels = '0;
		fmt_rate = '0;
		fmt_avg_bps = '0;
		fmt_align = '0;
		fmt_bits = '0;
	endtask

	task automatic wav_parse_step(input in_item_t beat, output bit got, output out_item_t r);
		logic [7:0] b;
		logic [2:0] code;
		b = beat.in_byte;
		code = ERR_NONE;
		got = 1'b0;
		r = '0;
		if (beat.end_of_file) begin
			case (pr_phase)
				PH_RIFF: code = ERR_NOT_RIFF;
				PH_FSIZE, PH_WAVE: code = ERR_NOT_WAVE;
				PH_CID, PH_CSIZE, PH_FMT, PH_SKIP: code = fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
				PH_DATA: code = ERR_SHORT;
				default: code = ERR_NONE;
			endcase
			parser_clear();
			if (code != ERR_NONE) begin
				got = 1'b1;
				r = error_beat(code);
			end
		end else begin
			case (pr_phase)
				PH_RIFF, PH_WAVE: begin
					pr_tag = {b, pr_tag[31:8]};
					pr_pos = pr_pos + 5'd1;
					if (pr_pos == 5'd4) begin
						pr_pos = '0;
						if (pr_phase == PH_RIFF) begin
							if (pr_tag != RIFF_ID)
								code = ERR_NOT_RIFF;
							else
								pr_phase = PH_FSIZE;
						end else begin
							if (pr_tag != WAVE_ID)
								code = ERR_NOT_WAVE;
							else
								pr_phase = PH_CID;
						end
					end
				end
				PH_FSIZE: begin
					pr_word = {b, pr_word[31:8]};
					pr_pos = pr_pos + 5'd1;
					if (pr_pos == 5'd4) begin
						pr_pos = '0;
						pr_phase = PH_WAVE;
					end
				end
				PH_CID: begin
					pr_tag = {b, pr_tag[31:8]};
					pr_pos = pr_pos + 5'd1;
					if (pr_pos == 5'd4) begin
						pr_pos = '0;
						pr_phase = PH_CSIZE;
					end
				end
				PH_CSIZE: begin
					pr_word = {b, pr_word[31:8]};
					pr_pos = pr_pos + 5'd1;
					if (pr_pos == 5'd4) begin
						pr_pos = '0;
						if (pr_tag == FMT_ID) begin
							pr_left = (pr_word > 32'd16) ? pr_word - 32'd16 : 32'd0;
							pr_phase = PH_FMT;
						end else if (pr_tag == DATA_ID) begin
							if (!fmt_seen) begin
								code = ERR_NO_FMT;
							end else begin
								got = 1'b1;
								r.result_kind = KIND_HEADER;
								r.format_tag = fmt_code;
								r.channel_count = fmt_channels;
								r.sample_rate_hz = fmt_rate;
								r.bytes_per_second = fmt_avg_bps;
								r.frame_bytes = fmt_align;
								r.sample_bits = fmt_bits;
								r.payload_length = pr_word;
								r.last_payload = (pr_word == 32'd0);
								pr_left = pr_word;
								pr_phase = (pr_word == 32'd0) ? PH_DONE : PH_DATA;
							end
						end else begin
							pr_left = pr_word;
							pr_phase = (pr_word == 32'd0) ? PH_CID : PH_SKIP;
						end
					end
				end
				PH_FMT: begin
					pr_word = {b, pr_word[31:8]};
					case (pr_pos)
						5'd1: fmt_code = pr_word[31:16];
						5'd3: fmt_channels = pr_word[31:16];
						5'd7: fmt_rate = pr_word;
						5'd11: fmt_avg_bps = pr_word;
						5'd13: fmt_align = pr_word[31:16];
						5'd15: fmt_bits = pr_word[31:16];
						default: ;
					endcase
					pr_pos = pr_pos + 5'd1;
					if (pr_pos == 5'd16) begin
						pr_pos = '0;
						fmt_seen = 1'b1;
						if (fmt_code != 16'd1)
							code = ERR_NOT_PCM;
						else
							pr_phase = (pr_left == 32'd0) ? PH_CID : PH_SKIP;
					end
				end
				PH_SKIP: begin
					pr_left = pr_left - 32'd1;
					if (pr_left == 32'd0)
						pr_phase = PH_CID;
				end
				PH_DATA: begin
					got = 1'b1;
					r.result_kind = KIND_PAYLOAD;
					r.payload_byte = b;
					r.last_payload = (pr_left == 32'd1);
					pr_left = pr_left - 32'd1;
					if (pr_left == 32'd0)
						pr_phase = PH_DONE;
				end
				default: ;
			endcase
			if (code != ERR_NONE) begin
				got = 1'b1;
				r = error_beat(code);
				pr_phase = PH_HALT;
			end
		end
	endtask

	// hold the beat until accepted, then queue what it should produce
	task automatic feed(input in_item_t beat, input bit typed, input bit has_want,
			input out_item_t want);
		int gap;
		bit got;
		out_item_t r;
		gap = pick_gap();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= beat;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sent_items++;
		wav_parse_step(beat, got, r);
		if (typed) begin
			if (has_want)
				results_due.push_back(want);
		end else if (got) begin
			results_due.push_back(r);
		end
	endtask

	task automatic add_row(input logic [7:0] b, input logic eof, input bit typed,
			input logic [2:0] code);
		probe_row_t row;
		row.beat.in_byte = b;
		row.beat.end_of_file = eof;
		row.typed = typed;
		row.has_want = typed && (code != ERR_NONE);
		row.want = error_beat(code);
		probe_rows.push_back(row);
	endtask

	task automatic put_le(input logic [31:0] w, input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(w[8*i +: 8]);
	endtask

	task automatic put_misc_chunks();
		logic [31:0] id;
		int n;
		int sz;
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			id = $urandom;
			if (id == FMT_ID || id == DATA_ID)
				id ^= 32'h1;
			sz = $urandom_range(0, 5);
			put_le(id, 4);
			put_le(sz, 4);
			repeat (sz) put_le($urandom, 1);
		end
	endtask

	task automatic put_fmt_chunk(input bit odd_tag);
		int r;
		int sz;
		int ext;
		logic [15:0] ftag, fch, falign, fbits;
		logic [31:0] frate, fbps;
		r = $urandom_range(0, 9);
		// short chunks still get a full 16-byte body
		sz = (r < 6) ? 16 : (r < 8) ? $urandom_range(17, 20) : $urandom_range(0, 15);
		ext = $urandom_range(0, 9);
		fch = 16'($urandom);
		frate = $urandom;
		fbps = $urandom;
		falign = 16'($urandom);
		fbits = 16'($urandom);
		if (ext == 0) begin
			fch = '1; frate = '1; fbps = '1; falign = '1; fbits = '1;
		end else if (ext == 1) begin
			fch = '0; frate = '0; fbps = '0; falign = '0; fbits = '0;
		end
		ftag = 16'd1;
		if (odd_tag) begin
			ftag = 16'($urandom);
			if (ftag == 16'd1)
				ftag = (ext == 0) ? 16'hFFFF : 16'h0000;
		end
		put_le(FMT_ID, 4);
		put_le(sz, 4);
		put_le(32'(ftag), 2);
		put_le(32'(fch), 2);
		put_le(frate, 4);
		put_le(fbps, 4);
		put_le(32'(falign), 2);
		put_le(32'(fbits), 2);
		if (sz > 16)
			repeat (sz - 16) put_le($urandom, 1);
	endtask

	task automatic put_data_chunk();
		int r;
		int nb;
		logic [31:0] sz;
		r = $urandom_range(0, 19);
		if (r < 5)
			sz = 32'd0;
		else if (r < 16)
			sz = $urandom_range(1, 12);
		else if (r < 19)
			sz = $urandom_range(13, 48);
		else begin
			// oversized length: the stream is cut off long before its end
			sz = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
			if (sz < 32'd49)
				sz = sz + 32'd49;
		end
		nb = (sz > 32'd48) ? $urandom_range(0, 6) : sz;
		put_le(DATA_ID, 4);
		put_le(sz, 4);
		repeat (nb) put_le($urandom, 1);
	endtask

	// kinds: noise, bad RIFF, bad WAVE, data before fmt, no data, non-PCM, normal
	task automatic make_file();
		int kind;
		int cut;
		logic [31:0] w;
		file_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 5) begin
			repeat ($urandom_range(0, 10)) put_le($urandom, 1);
		end else begin
			w = $urandom;
			if (w == RIFF_ID)
				w ^= 32'h100;
			put_le((kind < 9) ? w : RIFF_ID, 4);
			put_le($urandom, 4);
			w = $urandom;
			if (w == WAVE_ID)
				w ^= 32'h1;
			put_le((kind >= 9 && kind < 13) ? w : WAVE_ID, 4);
			if (kind >= 13) begin
				if (kind < 21)
					put_data_chunk();
				put_misc_chunks();
				put_fmt_chunk(kind >= 29 && kind < 37);
				if ($urandom_range(0, 4) == 0) begin
					put_misc_chunks();
					put_fmt_chunk(1'b0);
				end
				put_misc_chunks();
				if (kind < 21 || kind >= 29)
					put_data_chunk();
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) put_le($urandom, 1);
			if (kind >= 37 && $urandom_range(0, 6) == 0) begin
				cut = $urandom_range(0, file_bytes.size() - 1);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (results_due.size() == 0) begin
				$error("result beat with nothing expected: kind %0d", res_item.result_kind);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("result_kind", 32'(want.result_kind),
					32'(res_item.result_kind));
				check_field("error_code", 32'(want.error_code), 32'(res_item.error_code));
				check_field("format_tag", 32'(want.format_tag), 32'(res_item.format_tag));
				check_field("channel_count", 32'(want.channel_count),
					32'(res_item.channel_count));
				check_field("sample_rate_hz", want.sample_rate_hz, res_item.sample_rate_hz);
				check_field("bytes_per_second", want.bytes_per_second,
					res_item.bytes_per_second);
				check_field("frame_bytes", 32'(want.frame_bytes), 32'(res_item.frame_bytes));
				check_field("sample_bits", 32'(want.sample_bits), 32'(res_item.sample_bits));
				check_field("payload_length", want.payload_length, res_item.payload_length);
				check_field("payload_byte", 32'(want.payload_byte),
					32'(res_item.payload_byte));
				check_field("last_payload", 32'(want.last_payload),
					32'(res_item.last_payload));
			end
		end
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_left = pick_gap();
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		in_item_t beat;
		out_item_t none;
		none = '0;
		parser_clear();

		add_row(8'h00, 1'b1, 1'b1, ERR_NOT_RIFF);	// end of file straight after reset
		add_row(8'hFF, 1'b1, 1'b1, ERR_NOT_RIFF);	// and again back to back
		add_row(8'h52, 1'b0, 1'b1, ERR_NONE);	// "RIFX"
		add_row(8'h49, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h46, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h58, 1'b0, 1'b1, ERR_NOT_RIFF);
		add_row(8'hFF, 1'b0, 1'b1, ERR_NONE);	// dropped after an error
		add_row(8'h00, 1'b1, 1'b1, ERR_NONE);	// end of file after an error is silent
		add_row(8'h52, 1'b0, 1'b1, ERR_NONE);	// "RIFF", then cut off
		add_row(8'h49, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h46, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h46, 1'b0, 1'b1, ERR_NONE);
		add_row(8'hA5, 1'b1, 1'b1, ERR_NOT_WAVE);
		add_row(8'h52, 1'b0, 1'b1, ERR_NONE);	// "RIFF", max size, "WAVX"
		add_row(8'h49, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h46, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h46, 1'b0, 1'b1, ERR_NONE);
		add_row(8'hFF, 1'b0, 1'b0, ERR_NONE);
		add_row(8'hFF, 1'b0, 1'b0, ERR_NONE);
		add_row(8'hFF, 1'b0, 1'b0, ERR_NONE);
		add_row(8'hFF, 1'b0, 1'b0, ERR_NONE);
		add_row(8'h57, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h41, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h56, 1'b0, 1'b1, ERR_NONE);
		add_row(8'h58, 1'b0, 1'b1, ERR_NOT_WAVE);
		add_row(8'h00, 1'b1, 1'b1, ERR_NONE);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (probe_rows[i])
			feed(probe_rows[i].beat, probe_rows[i].typed, probe_rows[i].has_want,
				probe_rows[i].want);

		while (sent_items < ITEM_TARGET) begin
			make_file();
			foreach (file_bytes[i]) begin
				beat.in_byte = file_bytes[i];
				beat.end_of_file = 1'b0;
				feed(beat, 1'b0, 1'b0, none);
			end
			beat.in_byte = 8'($urandom);
			beat.end_of_file = 1'b1;
			feed(beat, 1'b0, 1'b0, none);
		end

		// drop valid right at the accepting edge of the last beat
		byte_valid <= 1'b0;
		for (int k = 0; k < 20000 && results_due.size() != 0; k++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d expected result beats never arrived", results_due.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
